// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int MAX_RESULTS    = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int PTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  localparam logic REG_STRICT   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [15:0] REPL_CHAR = 16'hFFFD;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_OK      = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] unit;
    logic [23:0] unit_count;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic [1:0]     n;
    res_t [2:0]     slot;
  } push_t;

  typedef struct packed {
    logic        strict_mode;
    logic [23:0] out_capacity;
  } cfg_t;

endpackage

// ===== rtl/u8u16_if.sv =====
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for input bytes and result beats.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, byte_in, last_byte, input ready);
  modport sink (input valid, byte_in, last_byte, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] unit;
  logic [23:0] unit_count;
  logic        run_end;

  modport source (output valid, kind, unit, unit_count, run_end, input ready);
  modport sink (input valid, kind, unit, unit_count, run_end, output ready);
endinterface

// ===== rtl/u8u16_cfg.sv =====
// ----------------------------------------------------------------------------
// u8u16_cfg
// APB register file: strict mode and output capacity.
// ----------------------------------------------------------------------------
module u8u16_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [u8u16_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output u8u16_pkg::cfg_t                     cfg
);
  import u8u16_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_STRICT:   cfg_nxt.strict_mode  = pwdata[0];
        REG_CAPACITY: cfg_nxt.out_capacity = pwdata[23:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STRICT:   prdata = {31'b0, cfg_r.strict_mode};
      REG_CAPACITY: prdata = {8'b0, cfg_r.out_capacity};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/u8u16_core.sv =====
// ----------------------------------------------------------------------------
// u8u16_core
// Input register, run state and the per-byte decode step.
// ----------------------------------------------------------------------------
module u8u16_core #(
  parameter int COUNT_BITS = u8u16_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  u8u16_pkg::cfg_t  cfg,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             in_ready,
  input  logic             room,
  output u8u16_pkg::push_t push
);
  import u8u16_pkg::*;

  typedef struct packed {
    logic [1:0]            err;
    logic [COUNT_BITS-1:0] uo;
    logic [1:0]            n;
    logic [15:0]           u0;
    logic [15:0]           u1;
    logic [20:0]           pc;
    logic [2:0]            el;
    logic [1:0]            bs;
  } st_t;

  logic                  s_valid_r, s_valid_nxt;
  logic [7:0]            s_byte_r;
  logic                  s_last_r;
  logic [20:0]           pc_r;
  logic [2:0]            el_r;
  logic [1:0]            bs_r;
  logic [COUNT_BITS-1:0] uo_r;
  logic [1:0]            err_r;
  logic                  accept;
  logic                  proc;
  st_t                   st;
  logic [20:0]           pc_new;
  logic [2:0]            seen;
  logic [31:0]           uo_ext;
  res_t                  fin;
  res_t [2:0]            slot;

  function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic st_t emit_unit(st_t s, logic [15:0] u, logic [23:0] cap);
    st_t r;
    r = s;
    if (s.err == ST_NONE) begin
      if (cap == '0) begin
        r.uo = bump(s.uo);
      end else if (32'(s.uo) >= 32'(cap)) begin
        r.err = ST_FULL;
      end else begin
        if (s.n == 2'd0) r.u0 = u;
        else r.u1 = u;
        r.n  = s.n + 2'd1;
        r.uo = bump(s.uo);
      end
    end
    return r;
  endfunction

  function automatic st_t emit_code(st_t s, logic [20:0] c, logic [23:0] cap);
    logic [20:0] v;
    st_t         r;
    v = c - 21'h10000;
    if (c < 21'h10000) begin
      r = emit_unit(s, c[15:0], cap);
    end else begin
      r = emit_unit(s, 16'hD800 | {6'b0, v[19:10]}, cap);
      r = emit_unit(r, 16'hDC00 | {6'b0, v[9:0]}, cap);
    end
    return r;
  endfunction

  function automatic st_t malformed(st_t s, logic strict, logic [23:0] cap);
    st_t r;
    r = s;
    if (strict) r.err = ST_INVALID;
    return emit_unit(r, REPL_CHAR, cap);
  endfunction

  function automatic st_t take_lead(st_t s, logic [7:0] b, logic strict,
                                    logic [23:0] cap);
    st_t r;
    r = s;
    if (b < 8'h80) begin
      r = emit_unit(s, {8'b0, b}, cap);
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      r.pc = {16'b0, b[4:0]};
      r.el = 3'd2;
      r.bs = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      r.pc = {17'b0, b[3:0]};
      r.el = 3'd3;
      r.bs = 2'd1;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      r.pc = {18'b0, b[2:0]};
      r.el = 3'd4;
      r.bs = 2'd1;
    end else begin
      r = malformed(s, strict, cap);
    end
    return r;
  endfunction

  function automatic logic trail_ok(st_t s, logic [7:0] b);
    logic ok;
    ok = (b[7:6] == 2'b10);
    if (ok && s.bs == 2'd1) begin
      if (s.el == 3'd3 && s.pc == 21'h0) ok = (b >= 8'hA0);
      else if (s.el == 3'd3 && s.pc == 21'hD) ok = (b < 8'hA0);
      else if (s.el == 3'd4 && s.pc == 21'h0) ok = (b >= 8'h90);
      else if (s.el == 3'd4 && s.pc == 21'h4) ok = (b < 8'h90);
    end
    return ok;
  endfunction

  assign in_ready = !s_valid_r || room;
  assign accept   = in_valid && in_ready;
  assign proc     = s_valid_r && room;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (accept) s_valid_nxt = 1'b1;
    else if (proc) s_valid_nxt = 1'b0;
  end

  always_comb begin
    st     = '{err: err_r, uo: uo_r, n: 2'd0, u0: 16'h0, u1: 16'h0,
               pc: pc_r, el: el_r, bs: bs_r};
    pc_new = {st.pc[14:0], s_byte_r[5:0]};
    seen   = {1'b0, st.bs} + 3'd1;
    if (st.err == ST_NONE) begin
      if (st.el != 3'd0) begin
        if (trail_ok(st, s_byte_r)) begin
          if (seen >= st.el) begin
            st.pc = '0;
            st.el = '0;
            st.bs = '0;
            st    = emit_code(st, pc_new, cfg.out_capacity);
          end else begin
            st.pc = pc_new;
            st.bs = seen[1:0];
          end
        end else begin
          st.pc = '0;
          st.el = '0;
          st.bs = '0;
          st    = malformed(st, cfg.strict_mode, cfg.out_capacity);
          if (st.err == ST_NONE) begin
            st = take_lead(st, s_byte_r, cfg.strict_mode, cfg.out_capacity);
          end
        end
      end else begin
        st = take_lead(st, s_byte_r, cfg.strict_mode, cfg.out_capacity);
      end
    end
    if (s_last_r) begin
      if (st.el != 3'd0 && st.err == ST_NONE) begin
        st = malformed(st, cfg.strict_mode, cfg.out_capacity);
      end
      st.pc = '0;
      st.el = '0;
      st.bs = '0;
    end
  end

  always_comb begin
    uo_ext         = 32'(st.uo);
    fin.kind       = (st.err == ST_NONE) ? KIND_OK : kind_t'(st.err);
    fin.unit       = 16'h0;
    fin.unit_count = (uo_ext > 32'h00FF_FFFF) ? 24'hFF_FFFF : uo_ext[23:0];
    fin.run_end    = 1'b1;
    slot           = '0;
    slot[0]        = '{kind: KIND_DATA, unit: st.u0, unit_count: 24'h0, run_end: 1'b0};
    slot[1]        = '{kind: KIND_DATA, unit: st.u1, unit_count: 24'h0, run_end: 1'b0};
    case (st.n)
      2'd0:    slot[0] = fin;
      2'd1:    slot[1] = fin;
      default: slot[2] = fin;
    endcase
    push.slot = slot;
    push.n    = proc ? (st.n + {1'b0, s_last_r}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_byte_r <= in_byte;
      s_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      pc_r      <= '0;
      el_r      <= '0;
      bs_r      <= '0;
      uo_r      <= '0;
      err_r     <= ST_NONE;
    end else begin
      s_valid_r <= s_valid_nxt;
      if (proc) begin
        pc_r  <= st.pc;
        el_r  <= st.el;
        bs_r  <= st.bs;
        uo_r  <= s_last_r ? '0 : st.uo;
        err_r <= s_last_r ? ST_NONE : st.err;
      end
    end
  end

endmodule

// ===== rtl/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue
// Result queue: takes up to three beats a cycle, hands out one.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  u8u16_pkg::push_t push,
  input  logic             pop,
  output logic             room,
  output logic             head_valid,
  output u8u16_pkg::res_t  head
);
  import u8u16_pkg::*;

  res_t                q_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                we [QUEUE_DEPTH];
  res_t                wdata [QUEUE_DEPTH];

  assign room       = count_r <= CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);
  assign head_valid = count_r != '0;
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      logic [PTR_BITS-1:0] k;
      k        = PTR_BITS'(e) - wr_ptr_r;
      we[e]    = {1'b0, k} < {1'b0, push.n};
      case (k)
        PTR_BITS'(0): wdata[e] = push.slot[0];
        PTR_BITS'(1): wdata[e] = push.slot[1];
        default:      wdata[e] = push.slot[2];
      endcase
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_BITS'(push.n);
    rd_ptr_nxt = rd_ptr_r + PTR_BITS'(pop);
    count_nxt  = count_r + CNT_BITS'(push.n) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      if (we[e]) q_r[e] <= wdata[e];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/utf8_to_utf16_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Decodes a UTF-8 byte stream into UTF-16 units with a closing status beat.
// ----------------------------------------------------------------------------
//  port      dir   beat
//  in_chan   sink  byte_in[7:0], last_byte
//  out_chan  src   kind[1:0], unit[15:0], unit_count[23:0], run_end
//  cfg_*     APB   reg 0 strict_mode @0x0, reg 1 out_capacity @0x4
//
//  One byte per cycle while each byte yields at most one beat and out_chan
//  is ready; a byte that yields two or three beats holds the input until the
//  queue has room again. A byte passes the input register, then the
//  four-entry result queue, on its way to the output.
//  Reset clears registers, run state and queue; no clearing pass.
//  An output stall backs up the queue; in_chan.ready drops once two beats wait.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
  parameter int COUNT_BITS = u8u16_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  u8u16_in_if.sink                            in_chan,
  u8u16_out_if.source                         out_chan,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [u8u16_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import u8u16_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  room;
  logic  head_valid;
  res_t  head;
  logic  pop;

  u8u16_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  u8u16_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_chan.valid),
    .in_byte  (in_chan.byte_in),
    .in_last  (in_chan.last_byte),
    .in_ready (in_chan.ready),
    .room     (room),
    .push     (push)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign pop                 = head_valid && out_chan.ready;
  assign out_chan.valid      = head_valid;
  assign out_chan.kind       = head.kind;
  assign out_chan.unit       = head.unit;
  assign out_chan.unit_count = head.unit_count;
  assign out_chan.run_end    = head.run_end;

endmodule

// ===== rtl/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_unit,
  input logic [23:0] out_unit_count,
  input logic        out_run_end
);
  import u8u16_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_final_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_end |-> out_kind != KIND_DATA && out_unit == 16'h0)
    else $error("closing beat carries a data unit");

  a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_end |-> out_kind == KIND_DATA && out_unit_count == 24'h0)
    else $error("data beat carries a status or count");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_kind       (out_chan.kind),
  .out_unit       (out_chan.unit),
  .out_unit_count (out_chan.unit_count),
  .out_run_end    (out_chan.run_end)
);

// ===== tb/utf8_to_utf16_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_tb
// Drives UTF-8 strings byte by byte into the decoder and checks every UTF-16
// beat against a transcoder kept inside the bench. Covers lax and strict
// decoding, count-only mode, small and full-range capacities, cut and
// malformed sequences, random idle cycles on both channels and a long output
// stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_tb;
  import u8u16_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  u8u16_in_if  in_chan ();
  u8u16_out_if out_chan ();

  utf8_to_utf16_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transcoder state and its copy of the registers
  logic        strict_q;
  logic [23:0] capacity_q;
  logic [20:0] seq_code;
  logic [2:0]  seq_len;
  logic [1:0]  seq_seen;
  logic [23:0] units_cnt;
  logic [1:0]  run_status;
  res_t        due_beats[$];
  res_t        want_beat;

  int fail_cnt = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int beats_seen = 0;
  int ends_ok = 0;
  int ends_invalid = 0;
  int ends_full = 0;
  int hold_cycles = 0;
  bit in_gaps = 1'b1;
  bit ready_gaps = 1'b1;

  function void seq_clear();
    seq_code = '0;
    seq_len = '0;
    seq_seen = '0;
  endfunction

  function void unit_emit(input logic [15:0] u);
    res_t r;
    if (run_status != ST_NONE) return;
    if (capacity_q != 0) begin
      if (units_cnt >= capacity_q) begin
        run_status = ST_FULL;
        return;
      end
      r.kind = KIND_DATA;
      r.unit = u;
      r.unit_count = '0;
      r.run_end = 1'b0;
      due_beats.push_back(r);
    end
    if (units_cnt != 24'hFFFFFF) units_cnt = units_cnt + 1'b1;
  endfunction

  function void code_emit(input logic [20:0] code);
    logic [19:0] v;
    if (code < 21'h10000) begin
      unit_emit(code[15:0]);
    end else begin
      v = 20'(code - 21'h10000);
      unit_emit({6'b110110, v[19:10]});
      unit_emit({6'b110111, v[9:0]});
    end
  endfunction

  function void bad_input();
    if (strict_q) run_status = ST_INVALID;
    unit_emit(REPL_CHAR);
  endfunction

  function void lead_take(input logic [7:0] b);
    if (b < 8'h80) begin
      unit_emit({8'h00, b});
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      seq_code = {16'h0, b[4:0]};
      seq_len = 3'd2;
      seq_seen = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      seq_code = {17'h0, b[3:0]};
      seq_len = 3'd3;
      seq_seen = 2'd1;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      seq_code = {18'h0, b[2:0]};
      seq_len = 3'd4;
      seq_seen = 2'd1;
    end else begin
      bad_input();
    end
  endfunction

  function bit trail_fits(input logic [7:0] b);
    if (b[7:6] != 2'b10) return 1'b0;
    if (seq_seen == 2'd1) begin
      if (seq_len == 3'd3 && seq_code == 21'h0) return b >= 8'hA0;
      if (seq_len == 3'd3 && seq_code == 21'hD) return b < 8'hA0;
      if (seq_len == 3'd4 && seq_code == 21'h0) return b >= 8'h90;
      if (seq_len == 3'd4 && seq_code == 21'h4) return b < 8'h90;
    end
    return 1'b1;
  endfunction

  function void decode_byte(input logic [7:0] b, input logic fin);
    logic [2:0]  seen;
    logic [20:0] code;
    res_t        r;
    if (run_status == ST_NONE) begin
      if (seq_len != 0) begin
        if (trail_fits(b)) begin
          seen = {1'b0, seq_seen} + 3'd1;
          seq_code = {seq_code[14:0], b[5:0]};
          if (seen >= seq_len) begin
            code = seq_code;
            seq_clear();
            code_emit(code);
          end else begin
            seq_seen = seen[1:0];
          end
        end else begin
          seq_clear();
          bad_input();
          if (run_status == ST_NONE) lead_take(b);
        end
      end else begin
        lead_take(b);
      end
    end
    if (fin) begin
      if (seq_len != 0 && run_status == ST_NONE) bad_input();
      seq_clear();
      case (run_status)
        ST_INVALID: r.kind = KIND_INVALID;
        ST_FULL:    r.kind = KIND_FULL;
        default:    r.kind = KIND_OK;
      endcase
      r.unit = '0;
      r.unit_count = units_cnt;
      r.run_end = 1'b1;
      due_beats.push_back(r);
      units_cnt = '0;
      run_status = ST_NONE;
      strings_sent++;
    end
  endfunction

  function automatic int utf8_encode(input logic [20:0] cp, output logic [31:0] seq);
    if (cp < 21'h80) begin
      seq = {cp[7:0], 24'h0};
      return 1;
    end
    if (cp < 21'h800) begin
      seq = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      return 2;
    end
    if (cp < 21'h10000) begin
      seq = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      return 3;
    end
    seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
    return 4;
  endfunction

  function automatic logic [20:0] rand_code();
    logic [20:0] cp;
    int cls;
    cls = $urandom_range(0, 10);
    if (cls < 4) begin
      cp = 21'($urandom_range(0, 'h7F));
    end else if (cls < 6) begin
      cp = 21'($urandom_range('h80, 'h7FF));
    end else if (cls < 8) begin
      cp = 21'($urandom_range('h800, 'hFFFF));
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h4000;
    end else if (cls < 10) begin
      cp = 21'($urandom_range('h10000, 'h10FFFF));
    end else begin
      case ($urandom_range(0, 7))
        0: cp = 21'h80;
        1: cp = 21'h7FF;
        2: cp = 21'h800;
        3: cp = 21'hD7FF;
        4: cp = 21'hE000;
        5: cp = 21'hFFFF;
        6: cp = 21'h10000;
        default: cp = 21'h10FFFF;
      endcase
    end
    return cp;
  endfunction

  task automatic byte_send(input logic [7:0] b, input logic fin);
    int gap;
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.byte_in <= b;
    in_chan.last_byte <= fin;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
    decode_byte(b, fin);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    for (int i = 0; i < seq.size(); i++) byte_send(seq[i], i == seq.size() - 1);
  endtask

  // build a string of well-formed characters, salted with stray bytes
  task automatic send_text(input int n_chars, input int noise_pct);
    logic [7:0]  bq[$];
    logic [31:0] enc;
    int          len;
    int          cut;
    for (int k = 0; k < n_chars; k++) begin
      len = utf8_encode(rand_code(), enc);
      cut = len;
      if ($urandom_range(1, 100) <= noise_pct) begin
        case ($urandom_range(0, 2))
          0: begin
            enc = {8'($urandom_range(0, 255)), 24'h0};
            cut = 1;
          end
          1: begin
            if (len > 1) cut = $urandom_range(1, len - 1);
            else enc = {8'h80 | 8'($urandom_range(0, 63)), 24'h0};
          end
          default: begin
            enc = {8'h80 | 8'($urandom_range(0, 63)), 24'h0};
            cut = 1;
          end
        endcase
      end
      for (int j = 0; j < cut; j++) bq.push_back(enc[31 - 8*j -: 8]);
    end
    send_bytes(bq);
  endtask

  // drop valid, wait out every due beat and the pipeline behind it
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [23:0] val);
    logic [31:0] word;
    word = (sel == REG_STRICT) ? {31'h0, val[0]} : {8'h0, val};
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == REG_STRICT) strict_q = val[0];
    else capacity_q = val;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== word) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: register %0d readback: expected %h, got %h", $realtime, sel, word,
                 cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_count_only();
    send_bytes('{8'h41, 8'hC3});
    settle();
  endtask

  task automatic test_lax_decode();
    cfg_write(REG_STRICT, 24'd0);
    cfg_write(REG_CAPACITY, 24'hFFFFFF);
    send_bytes('{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF,
                 8'hBF, 8'hFF, 8'hC1, 8'hED, 8'hA0, 8'hC3, 8'h41, 8'hE2});
    settle();
  endtask

  task automatic test_strict_stop();
    cfg_write(REG_STRICT, 24'd1);
    send_bytes('{8'h41, 8'h80, 8'h41});
    settle();
  endtask

  task automatic test_buffer_full();
    cfg_write(REG_STRICT, 24'd0);
    cfg_write(REG_CAPACITY, 24'd1);
    send_bytes('{8'hF0, 8'h9F, 8'h98, 8'h80});
    settle();
  endtask

  task automatic test_random_mix();
    int target;
    for (int p = 0; p < 6; p++) begin
      cfg_write(REG_STRICT, 24'(p % 2));
      case (p)
        0: cfg_write(REG_CAPACITY, 24'($urandom_range(1000, 'hFFFFFF)));
        1: cfg_write(REG_CAPACITY, 24'hFFFFFF);
        2, 3: cfg_write(REG_CAPACITY, 24'($urandom_range(1, 24)));
        default: cfg_write(REG_CAPACITY, 24'd0);
      endcase
      target = bytes_sent + 40;
      while (bytes_sent < target) send_text($urandom_range(1, 12), 20);
      settle();
    end
  endtask

  task automatic test_backpressure();
    cfg_write(REG_STRICT, 24'd0);
    cfg_write(REG_CAPACITY, 24'hFFFFFF);
    in_gaps = 1'b0;
    hold_cycles = 60;
    send_text(30, 0);
    settle();
    in_gaps = 1'b1;
  endtask

  task automatic test_full_rate();
    int target;
    in_gaps = 1'b0;
    ready_gaps = 1'b0;
    cfg_write(REG_STRICT, 24'($urandom_range(0, 1)));
    cfg_write(REG_CAPACITY, 24'hFFFFFF);
    target = bytes_sent + 80;
    while (bytes_sent < target) send_text($urandom_range(1, 12), 15);
  endtask

  initial begin : ready_ctl
    int n;
    out_chan.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        n = hold_cycles;
        hold_cycles = 0;
        repeat (n) @(posedge clk);
      end else if (ready_gaps && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      beats_seen++;
      if (due_beats.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: beat with nothing due: kind=%0d unit=%h count=%0d end=%b",
                   $realtime, out_chan.kind, out_chan.unit, out_chan.unit_count,
                   out_chan.run_end);
      end else begin
        want_beat = due_beats.pop_front();
        if (out_chan.kind !== want_beat.kind || out_chan.unit !== want_beat.unit ||
            out_chan.unit_count !== want_beat.unit_count ||
            out_chan.run_end !== want_beat.run_end) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: beat mismatch: expected kind=%0d unit=%h count=%0d end=%b",
                     $realtime, want_beat.kind, want_beat.unit, want_beat.unit_count,
                     want_beat.run_end);
            $display("%0t:                got      kind=%0d unit=%h count=%0d end=%b",
                     $realtime, out_chan.kind, out_chan.unit, out_chan.unit_count,
                     out_chan.run_end);
          end
        end
        if (want_beat.run_end) begin
          case (want_beat.kind)
            KIND_OK:      ends_ok++;
            KIND_INVALID: ends_invalid++;
            default:      ends_full++;
          endcase
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_chan.valid <= 1'b0;
    in_chan.byte_in <= 8'h00;
    in_chan.last_byte <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    strict_q = 1'b0;
    capacity_q = '0;
    units_cnt = '0;
    run_status = ST_NONE;
    seq_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_count_only();
    test_lax_decode();
    test_strict_stop();
    test_buffer_full();
    test_random_mix();
    test_backpressure();
    test_full_rate();

    in_chan.valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d strings, checked %0d output beats", bytes_sent,
             strings_sent, beats_seen);
    $display("Strings ended ok %0d, invalid %0d, buffer full %0d; lax, strict, count-only",
             ends_ok, ends_invalid, ends_full);
    if (fail_cnt == 0 && due_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d beats still due", fail_cnt, due_beats.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
